[design/hci_uart_h4_deframer_top_macros.svh]
// assertion macros shared by the deframer front end and queue
`ifndef HCI_UART_H4_DEFRAMER_TOP_MACROS_SVH
`define HCI_UART_H4_DEFRAMER_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define HUD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define HUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hud_pkg.sv]
// shared types and constants of the h4 deframer
package hud_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_CODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACL_CODE   = 8'd1;

    // reset values of the type codes
    localparam logic [BYTE_W-1:0] EVENT_CODE_RESET = 8'd4;
    localparam logic [BYTE_W-1:0] ACL_CODE_RESET   = 8'd2;

    // packet kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_ACL   = 1'b1;

    // one classified output item
    typedef struct packed {
        logic              packet_kind;
        logic [BYTE_W-1:0] data_byte;
        logic              in_header;
        logic              first_of_packet;
        logic              last_of_packet;
        logic [LEN_W-1:0]  payload_length;
    } hud_result_t;

    // queue state seen by the front and back ends
    typedef struct packed {
        logic full;
        logic head_valid;
    } hud_queue_stat_t;

endpackage

[design/hud_intf.sv]
// handshake interfaces of the deframer channels
interface hud_rx_if;
    logic                      valid;
    logic                      ready;
    logic [hud_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hud_tx_if;
    logic                       valid;
    logic                       ready;
    logic                       packet_kind;
    logic [hud_pkg::BYTE_W-1:0] data_byte;
    logic                       in_header;
    logic                       first_of_packet;
    logic                       last_of_packet;
    logic [hud_pkg::LEN_W-1:0]  payload_length;

    modport source (output valid, output packet_kind, output data_byte, output in_header,
                    output first_of_packet, output last_of_packet, output payload_length,
                    input ready);
    modport sink   (input valid, input packet_kind, input data_byte, input in_header,
                    input first_of_packet, input last_of_packet, input payload_length,
                    output ready);
endinterface

interface hud_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hud_pkg::CFG_IDX_W-1:0] index;
    logic [hud_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/hud_front.sv]
// front end: type code registers, packet parser and item classification
`include "hci_uart_h4_deframer_top_macros.svh"

module hud_front (
    input  logic                    clk,
    input  logic                    rst_n,
    hud_rx_if.sink                  rx,
    hud_cfg_if.sink                 cfg,
    input  hud_pkg::hud_queue_stat_t qstat,
    output logic                    push,
    output hud_pkg::hud_result_t    push_data
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_EVT_HDR,
        PH_ACL_HDR,
        PH_PAYLOAD
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic                        kind_reg, kind_next;
    logic [hud_pkg::LEN_W-1:0]   left_reg, left_next;
    logic [1:0]                  hpos_reg, hpos_next;
    logic [hud_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [hud_pkg::BYTE_W-1:0]  evt_code_reg, acl_code_reg;
    logic                        emit;
    logic                        rx_fire;
    logic [hud_pkg::LEN_W-1:0]   len_done;
    hud_pkg::hud_result_t        res;

    assign rx.ready  = !qstat.full;
    assign cfg.ready = 1'b1;
    assign rx_fire   = rx.valid && rx.ready;

    // parse one byte against the current phase
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        hpos_next  = hpos_reg;
        len_next   = len_reg;
        emit       = 1'b1;
        len_done   = '0;
        res.packet_kind     = kind_reg;
        res.data_byte       = rx.rx_byte;
        res.in_header       = 1'b1;
        res.first_of_packet = 1'b0;
        res.last_of_packet  = 1'b0;
        res.payload_length  = '0;
        case (phase_reg)
            PH_EVT_HDR:
            begin
                if (hpos_reg == 2'd0)
                begin
                    hpos_next       = 2'd1;
                    res.packet_kind = hud_pkg::KIND_EVENT;
                end
                else
                begin
                    len_done = {{(hud_pkg::LEN_W-hud_pkg::BYTE_W){1'b0}}, rx.rx_byte};
                end
            end
            PH_ACL_HDR:
            begin
                res.packet_kind = hud_pkg::KIND_ACL;
                if (hpos_reg == 2'd3)
                begin
                    res.packet_kind = kind_reg;
                    len_done = len_reg | {rx.rx_byte, {hud_pkg::BYTE_W{1'b0}}};
                end
                else
                begin
                    hpos_next = hpos_reg + 2'd1;
                    if (hpos_reg == 2'd2)
                    begin
                        len_next = {{(hud_pkg::LEN_W-hud_pkg::BYTE_W){1'b0}}, rx.rx_byte};
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res.in_header      = 1'b0;
                res.payload_length = len_reg;
                if (left_reg <= 16'd1)
                begin
                    res.last_of_packet = 1'b1;
                    left_next          = '0;
                    phase_next         = PH_WAIT;
                end
                else
                begin
                    left_next = left_reg - 16'd1;
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
                hpos_next  = 2'd0;
                len_next   = '0;
                left_next  = '0;
                res.first_of_packet = 1'b1;
                if (rx.rx_byte == evt_code_reg)
                begin
                    kind_next       = hud_pkg::KIND_EVENT;
                    res.packet_kind = hud_pkg::KIND_EVENT;
                    phase_next      = PH_EVT_HDR;
                end
                else if (rx.rx_byte == acl_code_reg)
                begin
                    kind_next       = hud_pkg::KIND_ACL;
                    res.packet_kind = hud_pkg::KIND_ACL;
                    phase_next      = PH_ACL_HDR;
                end
                else
                begin
                    emit = 1'b0;
                end
            end
        endcase

        // last header byte: zero length ends the packet here
        if ((phase_reg == PH_EVT_HDR && hpos_reg != 2'd0) ||
            (phase_reg == PH_ACL_HDR && hpos_reg == 2'd3))
        begin
            len_next           = len_done;
            left_next          = len_done;
            hpos_next          = 2'd0;
            res.payload_length = len_done;
            res.last_of_packet = (len_done == '0);
            phase_next         = (len_done == '0) ? PH_WAIT : PH_PAYLOAD;
        end
    end

    assign push      = rx_fire && emit;
    assign push_data = res;

    // parser state and type code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WAIT;
            kind_reg     <= hud_pkg::KIND_EVENT;
            left_reg     <= '0;
            hpos_reg     <= '0;
            len_reg      <= '0;
            evt_code_reg <= hud_pkg::EVENT_CODE_RESET;
            acl_code_reg <= hud_pkg::ACL_CODE_RESET;
        end
        else
        begin
            if (rx_fire)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                left_reg  <= left_next;
                hpos_reg  <= hpos_next;
                len_reg   <= len_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == hud_pkg::CFG_EVENT_CODE)
                begin
                    evt_code_reg <= cfg.data;
                end
                else if (cfg.index == hud_pkg::CFG_ACL_CODE)
                begin
                    acl_code_reg <= cfg.data;
                end
            end
        end
    end

    `HUD_ASSERT_ALWAYS(a_left_only_in_payload, phase_reg == PH_PAYLOAD || left_reg == '0, "bytes left outside payload")
    `HUD_ASSERT_ALWAYS(a_hpos_clear_when_idle, phase_reg != PH_WAIT || hpos_reg == 2'd0, "header position set while waiting")
    `HUD_ASSERT_NEXT(a_type_byte_opens, push && push_data.first_of_packet, phase_reg == PH_EVT_HDR || phase_reg == PH_ACL_HDR, "type byte did not open a header")

endmodule

[design/hud_queue.sv]
// short queue between the parser and the output stage
`include "hci_uart_h4_deframer_top_macros.svh"

module hud_queue #(
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  hud_pkg::hud_result_t     push_data,
    input  logic                     pop,
    output hud_pkg::hud_queue_stat_t stat,
    output hud_pkg::hud_result_t     head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hud_pkg::hud_result_t slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 do_push, do_pop;

    assign stat.full       = (count_reg == CNT_FULL);
    assign stat.head_valid = (count_reg != '0);
    assign head_data       = slot_reg[rd_ptr_reg];
    assign do_push         = push && !stat.full;
    assign do_pop          = pop && stat.head_valid;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `HUD_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_FULL, "queue count past depth")

endmodule

[design/hud_back.sv]
// back end: output register that drains the queue into the result channel
module hud_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hud_pkg::hud_queue_stat_t qstat,
    input  hud_pkg::hud_result_t     head_data,
    output logic                     pop,
    hud_tx_if.source                 tx
);

    logic                 out_valid_reg;
    hud_pkg::hud_result_t out_data_reg;

    // load when the register is empty or being taken
    assign pop = qstat.head_valid && (!out_valid_reg || tx.ready);

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= head_data;
        end
    end

    assign tx.valid           = out_valid_reg;
    assign tx.packet_kind     = out_data_reg.packet_kind;
    assign tx.data_byte       = out_data_reg.data_byte;
    assign tx.in_header       = out_data_reg.in_header;
    assign tx.first_of_packet = out_data_reg.first_of_packet;
    assign tx.last_of_packet  = out_data_reg.last_of_packet;
    assign tx.payload_length  = out_data_reg.payload_length;

endmodule

[design/hci_uart_h4_deframer_top.sv]
// top level of the hci uart h4 deframer
//
//   channel  direction  item
//   rx       in         one received serial byte (rx_byte)
//   tx       out        one packet byte with kind, header, first/last marks and length
//   cfg      in         type code write (index 0 event code, index 1 acl code)
//
// one byte is accepted per cycle unless the queue is full; the parser phase updates on accept
// an accepted byte reaches tx by way of the queue and then the output register
// rx.ready drops only while the QUEUE_DEPTH-entry queue is full, i.e. when tx stalls
// reset clears the parser to waiting for a type byte and restores codes 4 and 2
// cfg.ready is always high; unknown type bytes are consumed without an item
module hci_uart_h4_deframer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic     clk,
    input  logic     rst_n,
    hud_rx_if.sink   rx,
    hud_tx_if.source tx,
    hud_cfg_if.sink  cfg
);

    hud_pkg::hud_queue_stat_t qstat;
    hud_pkg::hud_result_t     push_data;
    hud_pkg::hud_result_t     head_data;
    logic                     push;
    logic                     pop;

    // parser
    hud_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue
    hud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .stat      (qstat),
        .head_data (head_data)
    );

    // output stage
    hud_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head_data (head_data),
        .pop       (pop),
        .tx        (tx)
    );

endmodule
